[src/wps_pkg.sv]
// Shared types, constants and a helper function for the water purifier stage controller.
package wps_pkg;

  localparam int unsigned VoltW     = 14;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned CurrentW  = 16;
  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned FlowW     = 16;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned MlW       = 32;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // Float switch positions within float_levels.
  localparam int unsigned FlHighSurf = 0;
  localparam int unsigned FlLowSurf  = 1;
  localparam int unsigned FlSec      = 2;
  localparam int unsigned FlLowFilt  = 3;
  localparam int unsigned FlHighFilt = 4;
  localparam int unsigned FlLowPur   = 5;
  localparam int unsigned FlHighPur  = 6;
  localparam int unsigned FlEnd      = 7;

  // UV run time is kept as whole hours plus leftover milliseconds.
  localparam int unsigned MsPerHour   = 3600;
  localparam int unsigned RunMsW      = 48;
  localparam int unsigned RunRemW     = 12;
  localparam int unsigned RunHoursW   = 37;
  localparam int unsigned RunSumW     = 17;
  localparam int unsigned HourStepW   = 5;
  localparam int unsigned MaxHourSteps =
    ((MsPerHour - 1) + ((1 << ElapsedW) - 1)) / MsPerHour;
  localparam logic [RunMsW-1:0] RunMsMax = '1;
  localparam logic [RunHoursW-1:0] RunHoursMax =
    RunHoursW'(RunMsMax / 64'(MsPerHour));
  localparam logic [RunRemW-1:0] RunRemMax =
    RunRemW'(RunMsMax % 64'(MsPerHour));

  // Fractional millilitres: the remainder product is divided by 3600 as
  // a shift by four and a reciprocal multiply for the division by 225.
  localparam int unsigned FracW       = RunRemW + FlowW;
  localparam int unsigned FracShift   = 4;
  localparam int unsigned RecipShift  = 32;
  localparam int unsigned RecipW      = 25;
  localparam int unsigned FracDivisor = MsPerHour >> FracShift;
  localparam logic [RecipW-1:0] RecipMul =
    RecipW'(((64'd1 << RecipShift) + 64'(FracDivisor) - 64'd1) / 64'(FracDivisor));
  localparam int unsigned RecipProdW  = FracW - FracShift + RecipW;
  localparam int unsigned FracMlW     = 16;
  localparam int unsigned HoursLoW    = 16;
  localparam int unsigned HoursHiW    = RunHoursW - HoursLoW;
  localparam int unsigned MlLoW       = HoursLoW + FlowW;
  localparam int unsigned MlHiW       = HoursHiW + FlowW;
  localparam int unsigned MlSumW      = MlHiW + HoursLoW + 1;

  typedef enum logic [ModeW-1:0] {
    MODE_TO_IDLE   = 3'd0,
    MODE_IDLE      = 3'd1,
    MODE_TO_PUMPS  = 3'd2,
    MODE_PUMPS     = 3'd3,
    MODE_TO_FILTER = 3'd4,
    MODE_FILTER    = 3'd5
  } mode_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_START_VOLT = 3'd0,
    CFG_STOP_VOLT  = 3'd1,
    CFG_UV_MIN     = 3'd2,
    CFG_UV_FLOW    = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [VoltW-1:0]    voltage;
    logic [LevelW-1:0]   float_levels;
    logic [CurrentW-1:0] uv_current;
    logic [ElapsedW-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic             well_pump;
    logic             end_pump;
    logic             uv_pump;
    logic             filter_relay;
    logic             uv_relay;
    logic             ac_inverter;
    logic             charge_relay;
    logic [ModeW-1:0] mode;
    logic [MlW-1:0]   purified_ml;
    logic             uv_fault;
  } out_item_t;

  typedef struct packed {
    logic well_pump;
    logic end_pump;
    logic uv_pump;
    logic filter_relay;
    logic uv_relay;
    logic ac_inverter;
    logic charge_relay;
  } drive_t;

  typedef struct packed {
    logic [VoltW-1:0]    start_volt;
    logic [VoltW-1:0]    stop_volt;
    logic [CurrentW-1:0] uv_min_current;
    logic [FlowW-1:0]    uv_pump_flow;
  } cfg_t;

  typedef struct packed {
    drive_t drv;
    mode_e  mode;
    logic   uv_fault;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [RunHoursW-1:0] run_hours;
    logic [RunRemW-1:0]   run_rem;
  } tick_t;

  function automatic logic [RunSumW-1:0] hour_ms(logic [HourStepW-1:0] n);
    return RunSumW'(n) * RunSumW'(MsPerHour);
  endfunction

endpackage

[src/wps_ctrl.sv]
// Mode sequencer, drive rules, lamp fault flag and UV run time accumulator.
module wps_ctrl import wps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output tick_t    tick_o
);

  mode_e                mode_q, mode_d;
  drive_t               drv_q, drv_d;
  logic                 fault_q, fault_d;
  logic                 acc_en;
  logic                 uv_start;
  logic [RunHoursW-1:0] hours_q, hours_d, hours_sum;
  logic [RunRemW-1:0]   rem_q, rem_d, rem_sum;
  logic [RunSumW-1:0]   run_sum;
  logic [MaxHourSteps-1:0] hour_ge;
  logic [HourStepW-1:0] hour_steps;
  logic                 run_sat;

  logic hs, ls, sec, lf, hf, lp, hp, en;
  logic [VoltW-1:0] volt;

  assign volt = item_i.voltage;
  assign hs   = item_i.float_levels[FlHighSurf];
  assign ls   = item_i.float_levels[FlLowSurf];
  assign sec  = item_i.float_levels[FlSec];
  assign lf   = item_i.float_levels[FlLowFilt];
  assign hf   = item_i.float_levels[FlHighFilt];
  assign lp   = item_i.float_levels[FlLowPur];
  assign hp   = item_i.float_levels[FlHighPur];
  assign en   = item_i.float_levels[FlEnd];

  // Next mode; a later rule in the same tick overrides an earlier one.
  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      MODE_IDLE: begin
        if (volt > cfg_i.start_volt) mode_d = MODE_TO_PUMPS;
      end
      MODE_TO_PUMPS: begin
        mode_d = MODE_PUMPS;
      end
      MODE_PUMPS: begin
        if (volt < cfg_i.stop_volt) mode_d = MODE_TO_IDLE;
        if (!lf && hs) mode_d = MODE_TO_FILTER;
      end
      MODE_TO_FILTER: begin
        if (volt >= cfg_i.start_volt) mode_d = MODE_FILTER;
      end
      MODE_FILTER: begin
        if (volt < cfg_i.stop_volt) mode_d = MODE_TO_IDLE;
        if (hf || !ls) mode_d = MODE_TO_PUMPS;
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase
  end

  // Drive rules; each rule sees the drives left by the rules above it.
  always_comb begin
    drv_d    = drv_q;
    fault_d  = fault_q;
    uv_start = 1'b0;
    acc_en   = 1'b0;
    case (mode_q)
      MODE_IDLE: begin
        drv_d = drv_q;
      end
      MODE_TO_PUMPS: begin
        drv_d.ac_inverter = 1'b0;
      end
      MODE_PUMPS: begin
        if (!drv_d.well_pump && !hs && sec) drv_d.well_pump = 1'b1;
        if (drv_d.well_pump && (hs || !sec)) drv_d.well_pump = 1'b0;
        if (!drv_d.uv_pump && !hp && lf) begin
          drv_d.ac_inverter = 1'b1;
          drv_d.uv_relay    = 1'b1;
          if (item_i.uv_current < cfg_i.uv_min_current) fault_d = 1'b1;
          drv_d.uv_pump = 1'b1;
          uv_start      = 1'b1;
        end
        // The tick on which the lamp starts adds no run time.
        if (drv_d.uv_pump && !uv_start) acc_en = 1'b1;
        if (drv_d.uv_pump && (!lf || hp)) begin
          drv_d.uv_pump     = 1'b0;
          drv_d.uv_relay    = 1'b0;
          drv_d.ac_inverter = 1'b0;
        end
        if (!drv_d.end_pump && !en && lp) drv_d.end_pump = 1'b1;
        if (drv_d.end_pump && (!lp || en)) drv_d.end_pump = 1'b0;
      end
      MODE_TO_FILTER: begin
        drv_d.well_pump   = 1'b0;
        drv_d.end_pump    = 1'b0;
        drv_d.uv_pump     = 1'b0;
        drv_d.ac_inverter = 1'b1;
        drv_d.uv_relay    = 1'b0;
        if (volt >= cfg_i.start_volt) drv_d.filter_relay = 1'b1;
      end
      MODE_FILTER: begin
        if (hf || !ls) drv_d.filter_relay = 1'b0;
      end
      default: begin
        drv_d = '0;
        drv_d.charge_relay = 1'b1;
      end
    endcase
  end

  // Run time: add the elapsed milliseconds to the leftover part and carry
  // whole hours out by comparing against every multiple of an hour that the sum can reach.
  always_comb begin
    run_sum = RunSumW'(rem_q) + RunSumW'(item_i.elapsed_ms);
    for (int k = 0; k < MaxHourSteps; k++) begin
      hour_ge[k] = run_sum >= hour_ms(HourStepW'(k + 1));
    end
    hour_steps = HourStepW'($countones(hour_ge));
    rem_sum    = RunRemW'(run_sum - hour_ms(hour_steps));
    hours_sum  = hours_q + RunHoursW'(hour_steps);
    run_sat    = (hours_sum > RunHoursMax) ||
                 ((hours_sum == RunHoursMax) && (rem_sum > RunRemMax));
    hours_d = hours_q;
    rem_d   = rem_q;
    if (acc_en) begin
      hours_d = run_sat ? RunHoursMax : hours_sum;
      rem_d   = run_sat ? RunRemMax : rem_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TO_IDLE;
      drv_q   <= '0;
      fault_q <= 1'b0;
      hours_q <= '0;
      rem_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      drv_q   <= drv_d;
      fault_q <= fault_d;
      hours_q <= hours_d;
      rem_q   <= rem_d;
    end
  end

  assign tick_o.side.drv      = drv_d;
  assign tick_o.side.mode     = mode_d;
  assign tick_o.side.uv_fault = fault_d;
  assign tick_o.run_hours     = hours_d;
  assign tick_o.run_rem       = rem_d;

endmodule

[src/wps_volume.sv]
// Pipeline that turns UV run time and pump flow into purified millilitres.
module wps_volume import wps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_valid_i,
  output logic             tick_ready_o,
  input  tick_t            tick_i,
  input  logic [FlowW-1:0] flow_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o
);

  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en0, en1, en2, en3, en4, en5;

  side_t                side0_q, side1_q, side2_q, side3_q, side4_q;
  logic [RunHoursW-1:0] hours0_q;
  logic [RunRemW-1:0]   rem0_q, rem1_q, rem2_q;
  logic [HoursHiW-1:0]  hhi1_q;
  logic [MlLoW-1:0]     mlo1_d, mlo1_q, mlo2_q, mlo3_q, mlo4_q;
  logic [MlHiW-1:0]     mhi2_d, mhi2_q, mhi3_q, mhi4_q;
  logic [FracW-1:0]     frac3_d, frac3_q;
  logic [RecipProdW-1:0] recip4;
  logic [FracMlW-1:0]   qr4_d, qr4_q;
  logic [MlSumW-1:0]    ml_sum;
  out_item_t            out_d, out_q;

  // A stage moves on when it is empty or the stage after it moves on.
  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign tick_ready_o = en0;

  assign mlo1_d  = MlLoW'(hours0_q[HoursLoW-1:0]) * MlLoW'(flow_i);
  assign mhi2_d  = MlHiW'(hhi1_q) * MlHiW'(flow_i);
  assign frac3_d = FracW'(rem2_q) * FracW'(flow_i);
  assign recip4  = RecipProdW'(frac3_q[FracW-1:FracShift]) * RecipProdW'(RecipMul);
  assign qr4_d   = recip4[RecipShift +: FracMlW];

  always_comb begin
    ml_sum = {1'b0, mhi4_q, {HoursLoW{1'b0}}} + MlSumW'(mlo4_q) + MlSumW'(qr4_q);
    out_d.well_pump    = side4_q.drv.well_pump;
    out_d.end_pump     = side4_q.drv.end_pump;
    out_d.uv_pump      = side4_q.drv.uv_pump;
    out_d.filter_relay = side4_q.drv.filter_relay;
    out_d.uv_relay     = side4_q.drv.uv_relay;
    out_d.ac_inverter  = side4_q.drv.ac_inverter;
    out_d.charge_relay = side4_q.drv.charge_relay;
    out_d.mode         = side4_q.mode;
    out_d.uv_fault     = side4_q.uv_fault;
    out_d.purified_ml  = (|ml_sum[MlSumW-1:MlW]) ? '1 : ml_sum[MlW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en0) v0_q <= tick_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && tick_valid_i) begin
      side0_q  <= tick_i.side;
      hours0_q <= tick_i.run_hours;
      rem0_q   <= tick_i.run_rem;
    end
    if (en1 && v0_q) begin
      side1_q <= side0_q;
      hhi1_q  <= hours0_q[RunHoursW-1:HoursLoW];
      rem1_q  <= rem0_q;
      mlo1_q  <= mlo1_d;
    end
    if (en2 && v1_q) begin
      side2_q <= side1_q;
      rem2_q  <= rem1_q;
      mlo2_q  <= mlo1_q;
      mhi2_q  <= mhi2_d;
    end
    if (en3 && v2_q) begin
      side3_q <= side2_q;
      mlo3_q  <= mlo2_q;
      mhi3_q  <= mhi2_q;
      frac3_q <= frac3_d;
    end
    if (en4 && v3_q) begin
      side4_q <= side3_q;
      mlo4_q  <= mlo3_q;
      mhi4_q  <= mhi3_q;
      qr4_q   <= qr4_d;
    end
    if (en5 && v4_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v5_q;
  assign out_item_o  = out_q;

endmodule

[src/water_purifier_stage_controller.sv]
// Top level of the water purifier stage controller: configuration registers and wiring.
//
// Each accepted request is one control tick: the mode sequencer, the pump and
// relay rules, the lamp current check and the UV run time update all settle in
// the cycle the request is taken, so a new request can be accepted on every
// clock unless the pipeline is full and the output stalled. The result for a
// tick leaves through a multiplier pipeline that converts run time (kept as
// whole hours plus leftover milliseconds) and the UV pump flow into purified
// millilitres, with its multiplies spread over separate stages. Every stage
// holds its item while the output is stalled, and empty stages keep accepting new requests meanwhile.
// Configuration writes are always accepted and take effect for the next tick;
// write them only while no tick is in flight.
module water_purifier_stage_controller import wps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t  cfg_q;
  tick_t tick;
  logic  in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_volt     <= VoltW'(2600);
      cfg_q.stop_volt      <= VoltW'(2300);
      cfg_q.uv_min_current <= CurrentW'(200);
      cfg_q.uv_pump_flow   <= FlowW'(300);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_VOLT: cfg_q.start_volt     <= cfg_data_i[VoltW-1:0];
        CFG_STOP_VOLT:  cfg_q.stop_volt      <= cfg_data_i[VoltW-1:0];
        CFG_UV_MIN:     cfg_q.uv_min_current <= cfg_data_i[CurrentW-1:0];
        CFG_UV_FLOW:    cfg_q.uv_pump_flow   <= cfg_data_i[FlowW-1:0];
        default:        cfg_q                <= cfg_q;
      endcase
    end
  end

  wps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_item_i),
    .cfg_i    (cfg_q),
    .tick_o   (tick)
  );

  wps_volume u_volume (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (in_valid_i),
    .tick_ready_o (in_ready_o),
    .tick_i       (tick),
    .flow_i       (cfg_q.uv_pump_flow),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

[src/wps_checker.sv]
// Port-level assertions for the water purifier stage controller, bound to the top level.
module wps_checker import wps_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  logic last_fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_fault_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      last_fault_q <= out_item_o.uv_fault;
    end
  end

  // A stalled result must not change or disappear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // The lamp fault flag never clears once it was reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_fault_q |-> out_item_o.uv_fault)
    else $error("uv fault flag cleared");

  // Idle means every load off with the charge relay closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.mode == MODE_IDLE) |->
      out_item_o.charge_relay && !out_item_o.well_pump && !out_item_o.end_pump &&
      !out_item_o.uv_pump && !out_item_o.filter_relay && !out_item_o.uv_relay &&
      !out_item_o.ac_inverter)
    else $error("drives active in idle");

  // Filtering has the filter relay and inverter on; pumps and lamp are off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.mode == MODE_FILTER) |->
      out_item_o.filter_relay && out_item_o.ac_inverter && !out_item_o.well_pump &&
      !out_item_o.end_pump && !out_item_o.uv_pump && !out_item_o.uv_relay)
    else $error("wrong drives while filtering");

endmodule

bind water_purifier_stage_controller wps_checker u_wps_checker (.*);
